// File: sv/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

  localparam int BITS_PER_PIXEL  = 32;
  localparam int BYTES_PER_PIXEL = BITS_PER_PIXEL / 8;
  localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);
  localparam int MAX_SIDE        = 256;
  localparam int ROW_ALIGN       = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] WIDTH_RESET  = 8'd32;
  localparam logic [7:0] HEIGHT_RESET = 8'd32;

  localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef struct packed {
    logic               done;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic signed [11:0] a;
    logic signed [11:0] b;
    logic [31:0]        color;
  } mcr_group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mcr_qstat_t;

  function automatic logic [8:0] mcr_clamp_side(input logic [7:0] side);
    logic [8:0] res;
    if (9'({1'b0, side}) > 9'(MAX_SIDE)) begin
      res = 9'(MAX_SIDE);
    end else begin
      res = {1'b0, side};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/mcr_front.sv
`default_nettype none

module mcr_front
  import mcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic signed [10:0] in_center_x,
  input  wire logic signed [10:0] in_center_y,
  input  wire logic [9:0]         in_radius,
  input  wire logic               in_fill,
  input  wire logic [31:0]        in_color,
  input  wire logic [8:0]         w_eff,
  input  wire logic [8:0]         h_eff,
  input  wire mcr_qstat_t         qstat,
  output logic                    push,
  output mcr_group_t              push_data
);

  logic signed [11:0] step_x_r, step_x_nxt;
  logic signed [11:0] step_y_r, step_y_nxt;
  logic signed [11:0] inner_y_r, inner_y_nxt;
  logic signed [13:0] decision_r, decision_nxt;
  logic signed [10:0] cx_r, cx_nxt;
  logic signed [10:0] cy_r, cy_nxt;
  logic               fill_r, fill_nxt;
  logic [31:0]        color_r, color_nxt;
  logic               active_r, active_nxt;

  logic               acc;
  logic               miss;
  logic               is_done;
  logic signed [12:0] cx13, cy13, r13, w13, h13;
  logic signed [15:0] x16, y16, d16;
  logic signed [11:0] x_adv, y_adv, inner_inc;
  logic signed [13:0] d_adv;

  assign in_ready = !qstat.full;
  assign acc      = in_valid && in_ready;
  assign is_done  = !active_r || (step_x_r > step_y_r);

  always_comb begin
    cx13 = 13'(in_center_x);
    cy13 = 13'(in_center_y);
    r13  = $signed({3'b000, in_radius});
    w13  = $signed({4'b0000, w_eff});
    h13  = $signed({4'b0000, h_eff});
    miss = (cx13 + r13 < 13'sd0) || (cx13 - r13 >= w13) ||
           (cy13 + r13 < 13'sd0) || (cy13 - r13 >= h13);

    x16 = 16'(step_x_r);
    y16 = 16'(step_y_r);
    d16 = 16'(decision_r);
    x_adv = step_x_r + 12'sd1;
    if (decision_r < 14'sd0) begin
      d_adv = 14'(d16 + (x16 <<< 2) + 16'sd6);
      y_adv = step_y_r;
    end else begin
      d_adv = 14'(d16 + ((x16 - y16) <<< 2) + 16'sd10);
      y_adv = step_y_r - 12'sd1;
    end
    inner_inc = inner_y_r + 12'sd1;

    step_x_nxt   = step_x_r;
    step_y_nxt   = step_y_r;
    inner_y_nxt  = inner_y_r;
    decision_nxt = decision_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    fill_nxt     = fill_r;
    color_nxt    = color_r;
    active_nxt   = active_r;

    if (acc && in_kind == KIND_START) begin
      if (miss) begin
        active_nxt = 1'b0;
      end else begin
        cx_nxt       = in_center_x;
        cy_nxt       = in_center_y;
        fill_nxt     = in_fill;
        color_nxt    = in_color;
        step_x_nxt   = 12'sd0;
        step_y_nxt   = $signed({2'b00, in_radius});
        inner_y_nxt  = in_fill ? 12'sd0 : $signed({2'b00, in_radius});
        decision_nxt = 14'sd3 - $signed({3'b000, in_radius, 1'b0});
        active_nxt   = 1'b1;
      end
    end else if (acc) begin
      if (is_done) begin
        active_nxt = 1'b0;
      end else if (fill_r && inner_inc <= step_y_r) begin
        inner_y_nxt = inner_inc;
      end else begin
        step_x_nxt   = x_adv;
        step_y_nxt   = y_adv;
        decision_nxt = d_adv;
        inner_y_nxt  = fill_r ? x_adv : y_adv;
      end
    end
  end

  assign push            = acc && in_kind == KIND_STEP;
  assign push_data.done  = is_done;
  assign push_data.cx    = cx_r;
  assign push_data.cy    = cy_r;
  assign push_data.a     = step_x_r;
  assign push_data.b     = inner_y_r;
  assign push_data.color = color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r   <= '0;
      step_y_r   <= '0;
      inner_y_r  <= '0;
      decision_r <= '0;
      cx_r       <= '0;
      cy_r       <= '0;
      fill_r     <= 1'b0;
      color_r    <= '0;
      active_r   <= 1'b0;
    end else begin
      step_x_r   <= step_x_nxt;
      step_y_r   <= step_y_nxt;
      inner_y_r  <= inner_y_nxt;
      decision_r <= decision_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      fill_r     <= fill_nxt;
      color_r    <= color_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mcr_queue.sv
`default_nettype none

module mcr_queue
  import mcr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire mcr_group_t push_data,
  input  wire logic       pop,
  output mcr_group_t      head,
  output mcr_qstat_t      qstat
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  mcr_group_t    mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign qstat.full  = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign qstat.empty = cnt_r == '0;
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: sv/mcr_back.sv
`default_nettype none

module mcr_back
  import mcr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire mcr_group_t head,
  input  wire mcr_qstat_t qstat,
  output logic            pop,
  input  wire logic [8:0] w_eff,
  input  wire logic [8:0] h_eff,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_pixel_x,
  output logic [7:0]      out_pixel_y,
  output logic [17:0]     out_byte_offset,
  output logic [31:0]     out_pixel_value,
  output logic            out_write_enable,
  output logic            out_done_res,
  output logic            out_last
);

  localparam int RW = $clog2(MAX_SIDE + ROW_ALIGN);

  mcr_group_t  cur_r, cur_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  px_r, px_nxt;
  logic [7:0]  py_r, py_nxt;
  logic [17:0] off_r, off_nxt;
  logic [31:0] val_r, val_nxt;
  logic        we_r, we_nxt;
  logic        done_r, done_nxt;
  logic        last_r, last_nxt;

  logic               out_free, fire, finish;
  logic signed [13:0] u14, v14, px14, py14, w14, h14;
  logic               in_image;
  logic [RW-1:0]      row_px;
  logic [17:0]        prod;
  logic [19:0]        off_full;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = cur_valid_r && out_free;
  assign finish   = fire && (cur_r.done || idx_r == 3'd7);
  assign pop      = !qstat.empty && (!cur_valid_r || finish);

  always_comb begin
    u14  = 14'(idx_r[2] ? cur_r.b : cur_r.a);
    v14  = 14'(idx_r[2] ? cur_r.a : cur_r.b);
    px14 = idx_r[0] ? 14'(cur_r.cx) - u14 : 14'(cur_r.cx) + u14;
    py14 = idx_r[1] ? 14'(cur_r.cy) - v14 : 14'(cur_r.cy) + v14;
    w14  = $signed({5'b00000, w_eff});
    h14  = $signed({5'b00000, h_eff});
    in_image = px14 >= 14'sd0 && px14 < w14 && py14 >= 14'sd0 && py14 < h14;
    row_px = (RW'(w_eff) + RW'(ROW_ALIGN - 1)) & ~RW'(ROW_ALIGN - 1);
    prod     = 18'(py14[7:0]) * 18'(row_px);
    off_full = (20'(prod) << BPP_SHIFT) + (20'(px14[7:0]) << BPP_SHIFT);
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_nxt       = head;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (finish) begin
      cur_valid_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end

    out_valid_nxt = out_valid_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    off_nxt  = off_r;
    val_nxt  = val_r;
    we_nxt   = we_r;
    done_nxt = done_r;
    last_nxt = last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (cur_r.done) begin
        px_nxt   = '0;
        py_nxt   = '0;
        off_nxt  = '0;
        val_nxt  = '0;
        we_nxt   = 1'b0;
        done_nxt = 1'b1;
        last_nxt = 1'b1;
      end else begin
        px_nxt   = in_image ? px14[7:0] : '0;
        py_nxt   = in_image ? py14[7:0] : '0;
        off_nxt  = in_image ? off_full[17:0] : '0;
        val_nxt  = cur_r.color;
        we_nxt   = in_image;
        done_nxt = 1'b0;
        last_nxt = idx_r == 3'd7;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    off_r  <= off_nxt;
    val_r  <= val_nxt;
    we_r   <= we_nxt;
    done_r <= done_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_byte_offset  = off_r;
  assign out_pixel_value  = val_r;
  assign out_write_enable = we_r;
  assign out_done_res     = done_r;
  assign out_last         = last_r;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> last_r && !we_r)
    else $error("done result must be last and disabled");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r &&
      $stable({px_r, py_r, off_r, val_r, we_r, done_r, last_r}))
    else $error("output request changed while stalled");
`endif

endmodule

`default_nettype wire

// File: sv/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer.
// Input channel (in_valid/in_ready): a start request (in_kind = 0) loads the
// center, radius, fill mode and color and returns nothing; a circle wholly
// outside the image is dropped. A step request (in_kind = 1) returns eight
// symmetric pixel writes, the eighth with out_last set, or one done result
// (out_done_res = out_last = 1) once the octant is covered.
// Result channel (out_valid/out_ready): one result per cycle from an output
// register unless stalled. Clipped: out_write_enable low and zero position.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 image width, 1 image height) at once; write only while idle.
// Timing: the front updates the circle state in the accept cycle and queues
// one group (depth two); a step's first result passes the queue, the current
// group register and the output register. The single result port limits
// throughput: eight results per drawing step, one per done step, starts none.
// Reset: no circle active, width and height 32, queue and output empty.
// Stall: a stalled receiver holds the output register; the queue then fills
// and in_ready drops.
`default_nettype none

module midpoint_circle_rasterizer
  import mcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic signed [10:0] in_center_x,
  input  wire logic signed [10:0] in_center_y,
  input  wire logic [9:0]         in_radius,
  input  wire logic               in_fill,
  input  wire logic [31:0]        in_color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_pixel_x,
  output logic [7:0]              out_pixel_y,
  output logic [17:0]             out_byte_offset,
  output logic [31:0]             out_pixel_value,
  output logic                    out_write_enable,
  output logic                    out_done_res,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);

  logic [7:0] width_r, width_nxt;
  logic [7:0] height_r, height_nxt;
  logic [8:0] w_eff, h_eff;

  mcr_qstat_t qstat;
  mcr_group_t push_data, head;
  logic       push, pop;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        CFG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign w_eff = mcr_clamp_side(width_r);
  assign h_eff = mcr_clamp_side(height_r);

  mcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .in_fill     (in_fill),
    .in_color    (in_color),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .qstat       (qstat),
    .push        (push),
    .push_data   (push_data)
  );

  mcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  mcr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .qstat            (qstat),
    .pop              (pop),
    .w_eff            (w_eff),
    .h_eff            (h_eff),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_byte_offset  (out_byte_offset),
    .out_pixel_value  (out_pixel_value),
    .out_write_enable (out_write_enable),
    .out_done_res     (out_done_res),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
